FILE: src/thsh_pkg.sv
// thsh_pkg: shared types, constants and the mixing table builder for the
// three-lane string hash stream; used by every module under src
`default_nettype none

package thsh_pkg;

	localparam int unsigned LANES    = 3;
	localparam int unsigned HASH_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned BUCKET_W = 18;
	localparam int unsigned ROM_D    = 256;

	localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
	localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
	localparam logic [31:0] GEN_START     = 32'h00100001;
	localparam logic [31:0] GEN_MUL       = 32'd125;
	localparam logic [31:0] GEN_MOD       = 32'h002AAAAB;
	localparam logic [31:0] GEN_INC       = 32'd3;
	localparam logic [31:0] HALF_MASK     = 32'h0000FFFF;
	localparam logic [31:0] HALF_SHIFT    = 32'h00000010;
	localparam int unsigned GEN_ROUNDS    = 5;
	localparam int unsigned SEED_SHIFT    = 5;

	typedef logic [ROM_D-1:0][HASH_W-1:0] lane_rom_t;

	typedef struct packed {
		logic [HASH_W-1:0] check_b;
		logic [HASH_W-1:0] check_a;
		logic [HASH_W-1:0] offset;
	} hash_set_t;

	// one lane's slice of the crypt table, worked out at elaboration
	function automatic lane_rom_t build_lane_rom(input int unsigned lane);
		lane_rom_t   rom;
		logic [31:0] s;
		logic [31:0] hi;
		rom = '0;
		s   = GEN_START;
		for (int unsigned c = 0; c < ROM_D; c++) begin
			for (int unsigned t = 0; t < GEN_ROUNDS; t++) begin
				s  = (s * GEN_MUL + GEN_INC) % GEN_MOD;
				hi = (s & HALF_MASK) << HALF_SHIFT;
				s  = (s * GEN_MUL + GEN_INC) % GEN_MOD;
				if (t == lane) begin
					rom[c] = hi | (s & HALF_MASK);
				end
			end
		end
		return rom;
	endfunction

endpackage

`default_nettype wire

FILE: src/thsh_lane.sv
// thsh_lane: one hash lane, its seed pair registers and its mixing table slice
// depends on thsh_pkg
`default_nettype none

module thsh_lane #(
	parameter int unsigned LANE = 0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step,
	input  wire logic                           restart,
	input  wire logic [thsh_pkg::BYTE_W-1:0]    key_byte,
	output logic      [thsh_pkg::HASH_W-1:0]    hash
);

	localparam thsh_pkg::lane_rom_t ROM = thsh_pkg::build_lane_rom(LANE);

	logic [thsh_pkg::HASH_W-1:0] seed_one_q;
	logic [thsh_pkg::HASH_W-1:0] seed_two_q;
	logic [thsh_pkg::HASH_W-1:0] mix;
	logic [thsh_pkg::HASH_W-1:0] one_nxt;
	logic [thsh_pkg::HASH_W-1:0] two_nxt;
	logic                        hashed;

	always_comb begin
		hashed  = (key_byte != '0);
		mix     = ROM[key_byte];
		one_nxt = mix ^ (seed_one_q + seed_two_q);
		two_nxt = thsh_pkg::HASH_W'(key_byte) + one_nxt + seed_two_q
			+ (seed_two_q << thsh_pkg::SEED_SHIFT) + thsh_pkg::GEN_INC;
		hash    = hashed ? one_nxt : seed_one_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= thsh_pkg::SEED_ONE_INIT;
			seed_two_q <= thsh_pkg::SEED_TWO_INIT;
		end else if (step) begin
			if (restart) begin
				seed_one_q <= thsh_pkg::SEED_ONE_INIT;
				seed_two_q <= thsh_pkg::SEED_TWO_INIT;
			end else if (hashed) begin
				seed_one_q <= one_nxt;
				seed_two_q <= two_nxt;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/thsh_bucket.sv
// thsh_bucket: result pipeline, start bucket by reciprocal multiply and one
// correction step, ending in the output register; depends on thsh_pkg
`default_nettype none

module thsh_bucket #(
	parameter int unsigned BUCKET_COUNT = 262144
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire thsh_pkg::hash_set_t             in_hash,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output thsh_pkg::hash_set_t                  out_hash,
	output logic      [thsh_pkg::BUCKET_W-1:0]   out_bucket
);

	localparam int unsigned FLOOR_LOG = $clog2(BUCKET_COUNT + 1) - 1;
	localparam int unsigned SHIFT     = 32 + FLOOR_LOG;
	localparam int unsigned BW        = $clog2(BUCKET_COUNT + 1);
	localparam int unsigned RW        = FLOOR_LOG + 2;
	localparam int unsigned QBW       = 32 + BW;
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) - 64'd1) / BUCKET_COUNT;
	localparam logic [31:0] RECIP     = RECIP_WIDE[31:0];
	localparam logic [BW-1:0] BUCKET_K = BW'(BUCKET_COUNT);

	thsh_pkg::hash_set_t hash_s2, hash_s3, hash_s4, hash_q;
	logic                valid_s2, valid_s3, valid_s4, valid_q;
	logic [31:0]         quot_s3;
	logic [RW-1:0]       rem_s4;
	logic [thsh_pkg::BUCKET_W-1:0] bucket_q;

	logic        rdy_q, rdy_s4, rdy_s3, rdy_s2;
	logic [63:0] recip_prod;
	logic [QBW-1:0] qb_prod;
	logic [RW-1:0]  rem_fix;
	logic [31:0]    rem_wide;

	always_comb begin
		rdy_q      = !valid_q || out_ready;
		rdy_s4     = !valid_s4 || rdy_q;
		rdy_s3     = !valid_s3 || rdy_s4;
		rdy_s2     = !valid_s2 || rdy_s3;
		recip_prod = 64'(hash_s2.offset) * 64'(RECIP);
		qb_prod    = QBW'(quot_s3) * QBW'(BUCKET_K);
		rem_fix    = (rem_s4 >= RW'(BUCKET_K)) ? rem_s4 - RW'(BUCKET_K) : rem_s4;
		rem_wide   = 32'(rem_fix);
	end

	assign in_ready   = rdy_s2;
	assign out_valid  = valid_q;
	assign out_hash   = hash_q;
	assign out_bucket = bucket_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (rdy_s2) valid_s2 <= in_valid;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_q)  valid_q  <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			hash_s2 <= in_hash;
		end
		if (rdy_s3) begin
			hash_s3 <= hash_s2;
			quot_s3 <= 32'(recip_prod >> SHIFT);
		end
		if (rdy_s4) begin
			hash_s4 <= hash_s3;
			rem_s4  <= RW'(hash_s3.offset - qb_prod[31:0]);
		end
		if (rdy_q) begin
			hash_q   <= hash_s4;
			bucket_q <= rem_wide[thsh_pkg::BUCKET_W-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: src/triple_string_hash_stream.sv
// triple_string_hash_stream: top level, input register, three hash lanes and
// the result pipeline; depends on thsh_pkg, thsh_lane and thsh_bucket
//
// A key enters one byte per item on s_axis, with tlast on its final byte; zero
// bytes are skipped, so an empty key is a single zero byte with tlast. One byte
// is taken every clock, save while a final byte waits on the bucket stages;
// each lane's combinational seed update (table read, add, xor, adds) sets the
// rate. A final byte goes through the input register and the bucket stages
// into one m_axis item: type 0, 1, 2 hashes and start bucket; all seeds restart.
// The bucket remainder runs through four registered stages that stall only
// when m_axis holds back; while it does, bytes that are not final still flow.
`default_nettype none

module triple_string_hash_stream #(
	parameter int unsigned BUCKET_COUNT = 262144
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // key_byte[7:0]
	input  wire logic         s_axis_tlast,   // is_last
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [119:0] m_axis_tdata    // hash_type0, hash_check_a,
	                                          // hash_check_b, start_bucket, pad
);

	logic                           valid_s1;
	logic                           last_s1;
	logic [thsh_pkg::BYTE_W-1:0]    byte_s1;
	logic                           advance_s1;
	logic                           bucket_ready;
	logic                           m_valid;
	logic [thsh_pkg::HASH_W-1:0]    lane_hash [thsh_pkg::LANES];
	thsh_pkg::hash_set_t            lane_set;
	thsh_pkg::hash_set_t            res_hash;
	logic [thsh_pkg::BUCKET_W-1:0]  res_bucket;

	always_comb begin
		advance_s1    = valid_s1 && (!last_s1 || bucket_ready);
		s_axis_tready = !valid_s1 || advance_s1;
		lane_set.offset  = lane_hash[0];
		lane_set.check_a = lane_hash[1];
		lane_set.check_b = lane_hash[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	for (genvar g = 0; g < thsh_pkg::LANES; g++) begin : g_lane
		thsh_lane #(
			.LANE(g)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.step    (advance_s1),
			.restart (last_s1),
			.key_byte(byte_s1),
			.hash    (lane_hash[g])
		);
	end

	thsh_bucket #(
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_bucket (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1 && last_s1),
		.in_ready  (bucket_ready),
		.in_hash   (lane_set),
		.out_valid (m_valid),
		.out_ready (m_axis_tready),
		.out_hash  (res_hash),
		.out_bucket(res_bucket)
	);

	assign m_axis_tvalid = m_valid;
	assign m_axis_tdata  = {6'b0, res_bucket, res_hash.check_b, res_hash.check_a,
		res_hash.offset};

endmodule

`default_nettype wire
